// ----- src/flcam_pkg.sv -----
// ----------------------------------------------------------------------------
// flcam_pkg
// Shared types, codes and fixed-point constants of the free-look camera.
// ----------------------------------------------------------------------------
package flcam_pkg;

  // Default number of CORDIC rotations and the hard upper limit.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  // Angles in Q16.16 degrees.
  localparam logic [24:0]        FULL_TURN      = 25'd23592960;
  localparam logic signed [34:0] FULL_TURN_X128 = 35'sd3019898880;
  localparam logic signed [34:0] PITCH_MAX      = 35'sd5832704;
  localparam logic signed [26:0] DEG_90         = 27'sd5898240;
  localparam logic signed [26:0] DEG_180        = 27'sd11796480;
  localparam logic signed [26:0] DEG_360        = 27'sd23592960;
  localparam logic signed [33:0] FOV_MIN        = 34'sd65536;
  localparam logic signed [33:0] FOV_MAX        = 34'sd2949120;

  // CORDIC start value in Q1.30 (prescaled by the fixed gain).
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;

  localparam logic signed [15:0] ONE14 = 16'sd16384;

  // Reset values.
  localparam logic [24:0] YAW_RESET   = 25'd17694720;
  localparam logic [13:0] FOV_RESET   = 14'd11520;
  localparam logic [15:0] SENS_RESET  = 16'd6554;
  localparam logic [15:0] SPEED_RESET = 16'd640;

  typedef enum logic [2:0] {
    CMD_LOOK  = 3'd0,
    CMD_ZOOM  = 3'd1,
    CMD_FWD   = 3'd2,
    CMD_BACK  = 3'd3,
    CMD_LEFT  = 3'd4,
    CMD_RIGHT = 3'd5,
    CMD_UP    = 3'd6,
    CMD_DOWN  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SENS  = 3'd0,
    REG_SPEED = 3'd1,
    REG_WUP_X = 3'd2,
    REG_WUP_Y = 3'd3,
    REG_WUP_Z = 3'd4
  } reg_idx_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DX,
    OP_DY,
    OP_YRED,
    OP_CINIT,
    OP_CSTEP,
    OP_CFIN,
    OP_FMUL0,
    OP_FMUL2,
    OP_SQ,
    OP_SQRTI,
    OP_SQRT,
    OP_DIVI,
    OP_DSTEP,
    OP_DFIN,
    OP_CROSS,
    OP_ZOOM,
    OP_VEL,
    OP_MOVE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] cnt;   // step index of the running iteration
    logic [1:0] comp;  // vector component
    logic [1:0] sel;   // CORDIC angle or normalize target
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;         // latched command of the item in work
  } dp_stat_t;

  // atan(2^-i) in Q16.16 degrees.
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117266;
      5'd6:  r = 22'd58665;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/free_look_camera_update.sv -----
// ----------------------------------------------------------------------------
// free_look_camera_update
// Euler-angle free-look camera: look, zoom and move steps on a fixed-point
// camera state, one result per command.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    command, offsets, delta time
//   out_      output     out_valid / out_ready  position, front, up, fov, angles
//   cfg_      input      cfg_we (no wait)       register index, 16-bit data
//
// A look command runs three normalizations, each a sum of squares, a square
// root and three restoring divisions, plus two passes through the CORDIC
// unit, whose rotation count CORDIC_STEPS is capped at 24.
// A zoom is one clamped field-of-view update; a move computes the velocity
// and then steps the three position components.
// Reset is synchronous and active low; it restores the camera pose and the
// configuration registers to their defaults.
// A new command is accepted while a finished result still waits in the
// output register; the sequencer stalls only when that register is still
// occupied at the end of the next command.
// ----------------------------------------------------------------------------
module free_look_camera_update #(
  parameter int CORDIC_STEPS = flcam_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration writes.
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  // Command input.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_x_offset,
  input  logic signed [31:0] in_y_offset,
  input  logic [15:0]        in_delta_time,
  // Result output.
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic [13:0]        out_field_of_view,
  output logic [24:0]        out_yaw_out,
  output logic signed [23:0] out_pitch_out
);

  // The controller issues one datapath operation per cycle; the datapath
  // reports back the command of the transfer it latched.
  flcam_pkg::dp_cmd_t  dp_cmd;
  flcam_pkg::dp_stat_t dp_stat;

  flcam_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // The datapath holds the pose, the configuration and all arithmetic.
  // Yaw is reduced modulo a full turn by eight conditional subtractions,
  // and vectors are normalized by a bitwise square root and a divider.
  flcam_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_x_offset       (in_x_offset),
    .in_y_offset       (in_y_offset),
    .in_delta_time     (in_delta_time),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_front_x       (out_front_x),
    .out_front_y       (out_front_y),
    .out_front_z       (out_front_z),
    .out_up_x          (out_up_x),
    .out_up_y          (out_up_y),
    .out_up_z          (out_up_z),
    .out_field_of_view (out_field_of_view),
    .out_yaw_out       (out_yaw_out),
    .out_pitch_out     (out_pitch_out)
  );

endmodule

// ----- src/flcam_ctrl.sv -----
// ----------------------------------------------------------------------------
// flcam_ctrl
// Sequencer of the camera update: walks each command through its steps.
// ----------------------------------------------------------------------------
module flcam_ctrl #(
  parameter int CORDIC_STEPS = flcam_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  flcam_pkg::dp_stat_t stat,
  output flcam_pkg::dp_cmd_t  cmd
);

  localparam int STEPS_EFF = (CORDIC_STEPS > flcam_pkg::CORDIC_STEPS_MAX) ?
                             flcam_pkg::CORDIC_STEPS_MAX : CORDIC_STEPS;
  localparam logic [4:0] STEP_LAST = 5'(STEPS_EFF - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_DX, S_DY, S_YRED, S_CINIT, S_CSTEP, S_CFIN,
    S_FMUL0, S_FMUL2, S_SQ, S_SQRTI, S_SQRT, S_DIVI, S_DSTEP, S_DFIN,
    S_CROSS, S_ZOOM, S_VEL, S_MOVE, S_DONE
  } state_t;

  state_t     state_r;
  logic [4:0] cnt_r;
  logic [1:0] comp_r;
  logic [1:0] sel_r;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the publish step below decides the flag on its own.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          case (stat.cmd)
            flcam_pkg::CMD_LOOK: state_r <= S_DX;
            flcam_pkg::CMD_ZOOM: state_r <= S_ZOOM;
            default:             state_r <= S_VEL;
          endcase
        end
        S_DX: state_r <= S_DY;
        S_DY: begin
          state_r <= S_YRED;
          cnt_r   <= 5'd7;
        end
        S_YRED: begin
          if (cnt_r == 5'd0) begin
            state_r <= S_CINIT;
            sel_r   <= 2'd0;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_CINIT: begin
          state_r <= S_CSTEP;
          cnt_r   <= 5'd0;
        end
        S_CSTEP: begin
          if (cnt_r == STEP_LAST) begin
            state_r <= S_CFIN;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_CFIN: begin
          if (sel_r == 2'd0) begin
            sel_r   <= 2'd1;
            state_r <= S_CINIT;
          end else begin
            state_r <= S_FMUL0;
          end
        end
        S_FMUL0: state_r <= S_FMUL2;
        S_FMUL2: begin
          sel_r   <= 2'd0;
          comp_r  <= 2'd0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (comp_r == 2'd2) begin
            state_r <= S_SQRTI;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_SQRTI: begin
          cnt_r   <= 5'd0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_r == 5'd31) begin
            comp_r  <= 2'd0;
            state_r <= S_DIVI;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_DIVI: begin
          cnt_r   <= 5'd16;
          state_r <= S_DSTEP;
        end
        S_DSTEP: begin
          if (cnt_r == 5'd0) begin
            state_r <= S_DFIN;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_DFIN: begin
          if (comp_r != 2'd2) begin
            comp_r  <= comp_r + 2'd1;
            state_r <= S_DIVI;
          end else if (sel_r != 2'd2) begin
            sel_r   <= sel_r + 2'd1;
            comp_r  <= 2'd0;
            state_r <= S_CROSS;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CROSS: begin
          if (comp_r == 2'd2) begin
            comp_r  <= 2'd0;
            state_r <= S_SQ;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_ZOOM: state_r <= S_DONE;
        S_VEL: begin
          comp_r  <= 2'd0;
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          if (comp_r == 2'd2) begin
            state_r <= S_DONE;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op   = flcam_pkg::OP_NONE;
    cmd.cnt  = cnt_r;
    cmd.comp = comp_r;
    cmd.sel  = sel_r;
    unique case (state_r)
      S_IDLE:  cmd.op = in_valid ? flcam_pkg::OP_LOAD : flcam_pkg::OP_NONE;
      S_DISP:  cmd.op = flcam_pkg::OP_NONE;
      S_DX:    cmd.op = flcam_pkg::OP_DX;
      S_DY:    cmd.op = flcam_pkg::OP_DY;
      S_YRED:  cmd.op = flcam_pkg::OP_YRED;
      S_CINIT: cmd.op = flcam_pkg::OP_CINIT;
      S_CSTEP: cmd.op = flcam_pkg::OP_CSTEP;
      S_CFIN:  cmd.op = flcam_pkg::OP_CFIN;
      S_FMUL0: cmd.op = flcam_pkg::OP_FMUL0;
      S_FMUL2: cmd.op = flcam_pkg::OP_FMUL2;
      S_SQ:    cmd.op = flcam_pkg::OP_SQ;
      S_SQRTI: cmd.op = flcam_pkg::OP_SQRTI;
      S_SQRT:  cmd.op = flcam_pkg::OP_SQRT;
      S_DIVI:  cmd.op = flcam_pkg::OP_DIVI;
      S_DSTEP: cmd.op = flcam_pkg::OP_DSTEP;
      S_DFIN:  cmd.op = flcam_pkg::OP_DFIN;
      S_CROSS: cmd.op = flcam_pkg::OP_CROSS;
      S_ZOOM:  cmd.op = flcam_pkg::OP_ZOOM;
      S_VEL:   cmd.op = flcam_pkg::OP_VEL;
      S_MOVE:  cmd.op = flcam_pkg::OP_MOVE;
      S_DONE:  cmd.op = out_free ? flcam_pkg::OP_PUBLISH : flcam_pkg::OP_NONE;
      default: cmd.op = flcam_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- src/flcam_dp.sv -----
// ----------------------------------------------------------------------------
// flcam_dp
// Camera state, configuration registers and the shared arithmetic units
// (CORDIC, square root, restoring divider, multipliers) driven one
// operation per cycle.
// ----------------------------------------------------------------------------
module flcam_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic [2:0]          in_command,
  input  logic signed [31:0]  in_x_offset,
  input  logic signed [31:0]  in_y_offset,
  input  logic [15:0]         in_delta_time,
  input  flcam_pkg::dp_cmd_t  cmd,
  output flcam_pkg::dp_stat_t stat,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z,
  output logic signed [15:0]  out_front_x,
  output logic signed [15:0]  out_front_y,
  output logic signed [15:0]  out_front_z,
  output logic signed [15:0]  out_up_x,
  output logic signed [15:0]  out_up_y,
  output logic signed [15:0]  out_up_z,
  output logic [13:0]         out_field_of_view,
  output logic [24:0]         out_yaw_out,
  output logic signed [23:0]  out_pitch_out
);

  // Configuration.
  logic [15:0]        sens_r;
  logic [15:0]        speed_r;
  logic signed [15:0] wup_r [3];

  // Latched item.
  flcam_pkg::cmd_t    cmd_r;
  logic signed [31:0] xo_r;
  logic signed [31:0] yo_r;
  logic [15:0]        dt_r;

  // Camera state.
  logic signed [31:0] pos_r [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r [3];
  logic [24:0]        yaw_r;
  logic signed [23:0] pitch_r;
  logic [13:0]        fov_r;

  // Working registers.
  logic signed [34:0] red_r;
  logic signed [32:0] cx_r;
  logic signed [32:0] cy_r;
  logic signed [26:0] ca_r;
  logic               neg_r;
  logic signed [31:0] cosy_r;
  logic signed [31:0] siny_r;
  logic signed [31:0] cosp_r;
  logic signed [31:0] sinp_r;
  logic signed [31:0] v_r [3];
  logic [63:0]        sum_r;
  logic [63:0]        sn_r;
  logic [63:0]        sr_r;
  logic [47:0]        rem_r;
  logic [32:0]        den_r;
  logic [16:0]        q_r;
  logic [31:0]        vel_r;

  // Output register.
  logic signed [31:0] opos_r [3];
  logic signed [15:0] ofront_r [3];
  logic signed [15:0] oup_r [3];
  logic [13:0]        ofov_r;
  logic [24:0]        oyaw_r;
  logic signed [23:0] opitch_r;

  assign stat.cmd = cmd_r;

  // Look offsets scaled by the sensitivity, yaw wrap, pitch clamp and yaw reduction.
  logic signed [48:0] dx_prod, dy_prod;
  logic signed [32:0] dx, dy;
  logic signed [34:0] yaw_sum, yaw_wrap, pitch_diff;
  logic signed [23:0] pitch_nxt;
  logic signed [34:0] red_thr, red_sub;
  logic               red_ge;

  always_comb begin
    dx_prod    = xo_r * $signed({1'b0, sens_r});
    dy_prod    = yo_r * $signed({1'b0, sens_r});
    dx         = dx_prod[48:16];
    dy         = dy_prod[48:16];
    yaw_sum    = $signed({10'd0, yaw_r}) + $signed({{2{dx[32]}}, dx});
    yaw_wrap   = (yaw_sum < 0) ? yaw_sum + flcam_pkg::FULL_TURN_X128 : yaw_sum;
    pitch_diff = $signed({{11{pitch_r[23]}}, pitch_r}) - $signed({{2{dy[32]}}, dy});
    if (pitch_diff > flcam_pkg::PITCH_MAX) begin
      pitch_nxt = flcam_pkg::PITCH_MAX[23:0];
    end else if (pitch_diff < -flcam_pkg::PITCH_MAX) begin
      pitch_nxt = 24'(-flcam_pkg::PITCH_MAX);
    end else begin
      pitch_nxt = pitch_diff[23:0];
    end
    red_thr = $signed({10'd0, flcam_pkg::FULL_TURN}) <<< cmd.cnt[2:0];
    red_ge  = (red_r >= red_thr);
    red_sub = red_ge ? red_r - red_thr : red_r;
  end

  // CORDIC: angle folding at start, one rotation per cycle.
  logic signed [26:0] ang0, ang1, ang_nxt;
  logic               neg_nxt;
  logic signed [32:0] sx, sy;
  logic signed [26:0] atan_w;
  logic               rot_pos;
  logic signed [32:0] cos_fin, sin_fin;

  always_comb begin
    ang0 = (cmd.sel == 2'd0) ? $signed({2'b00, yaw_r}) :
                               $signed({{3{pitch_r[23]}}, pitch_r});
    if (ang0 > flcam_pkg::DEG_180) begin
      ang1 = ang0 - flcam_pkg::DEG_360;
    end else if (ang0 < -flcam_pkg::DEG_180) begin
      ang1 = ang0 + flcam_pkg::DEG_360;
    end else begin
      ang1 = ang0;
    end
    if (ang1 > flcam_pkg::DEG_90) begin
      ang_nxt = ang1 - flcam_pkg::DEG_180;
      neg_nxt = 1'b1;
    end else if (ang1 < -flcam_pkg::DEG_90) begin
      ang_nxt = ang1 + flcam_pkg::DEG_180;
      neg_nxt = 1'b1;
    end else begin
      ang_nxt = ang1;
      neg_nxt = 1'b0;
    end
    sx      = cx_r >>> cmd.cnt;
    sy      = cy_r >>> cmd.cnt;
    atan_w  = $signed({5'd0, flcam_pkg::atan_deg(cmd.cnt)});
    rot_pos = (ca_r >= 0);
    cos_fin = neg_r ? -cx_r : cx_r;
    sin_fin = neg_r ? -cy_r : cy_r;
  end

  // Raw front vector and cross products.
  logic signed [63:0] fp0, fp2;
  logic signed [15:0] ca_p, ca_q, cb_p, cb_q;
  logic signed [31:0] cp_a, cp_b;
  logic signed [31:0] cross_v;

  always_comb begin
    fp0 = cosy_r * cosp_r;
    fp2 = siny_r * cosp_r;
    ca_p = '0;
    ca_q = '0;
    cb_p = '0;
    cb_q = '0;
    // a is front and b is world up for right; a is right and b is front for up.
    case (cmd.comp)
      2'd0: begin
        ca_p = (cmd.sel == 2'd1) ? front_r[1] : right_r[1];
        ca_q = (cmd.sel == 2'd1) ? front_r[2] : right_r[2];
        cb_p = (cmd.sel == 2'd1) ? wup_r[1] : front_r[1];
        cb_q = (cmd.sel == 2'd1) ? wup_r[2] : front_r[2];
      end
      2'd1: begin
        ca_p = (cmd.sel == 2'd1) ? front_r[2] : right_r[2];
        ca_q = (cmd.sel == 2'd1) ? front_r[0] : right_r[0];
        cb_p = (cmd.sel == 2'd1) ? wup_r[2] : front_r[2];
        cb_q = (cmd.sel == 2'd1) ? wup_r[0] : front_r[0];
      end
      default: begin
        ca_p = (cmd.sel == 2'd1) ? front_r[0] : right_r[0];
        ca_q = (cmd.sel == 2'd1) ? front_r[1] : right_r[1];
        cb_p = (cmd.sel == 2'd1) ? wup_r[0] : front_r[0];
        cb_q = (cmd.sel == 2'd1) ? wup_r[1] : front_r[1];
      end
    endcase
    cp_a    = ca_p * cb_q;
    cp_b    = ca_q * cb_p;
    cross_v = cp_a - cp_b;
  end

  // Normalize: sum of squares, bitwise square root, restoring division.
  logic signed [31:0] vsel;
  logic [31:0]        mag;
  logic [63:0]        sq;
  logic [5:0]         sqrt_sh;
  logic [63:0]        sqrt_bit;
  logic [64:0]        sqrt_trial;
  logic               sqrt_ge;
  logic [31:0]        len;
  logic [47:0]        div_num;
  logic [49:0]        div_thr;
  logic               div_ge;
  logic [15:0]        q_mag;
  logic signed [15:0] norm_res;

  always_comb begin
    vsel       = v_r[cmd.comp];
    mag        = vsel[31] ? 32'(-vsel) : 32'(vsel);
    sq         = mag * mag;
    sqrt_sh    = 6'd62 - {cmd.cnt, 1'b0};
    sqrt_bit   = 64'd1 << sqrt_sh;
    sqrt_trial = {1'b0, sr_r} + {1'b0, sqrt_bit};
    sqrt_ge    = ({1'b0, sn_r} >= sqrt_trial);
    len        = sr_r[31:0];
    div_num    = {1'b0, mag, 15'd0} + {16'd0, len};
    div_thr    = {17'd0, den_r} << cmd.cnt;
    div_ge     = ({2'b00, rem_r} >= div_thr);
    q_mag      = (q_r > 17'd16384) ? 16'd16384 : q_r[15:0];
    if (len == 32'd0) begin
      norm_res = '0;
    end else if (vsel[31]) begin
      norm_res = -$signed(q_mag);
    end else begin
      norm_res = $signed(q_mag);
    end
  end

  // Move and zoom.
  logic signed [15:0] mvec;
  logic               mminus;
  logic signed [48:0] mprod, mround;
  logic signed [26:0] mstep;
  logic signed [33:0] mpos;
  logic signed [31:0] mpos_sat;
  logic signed [33:0] fz;
  logic [13:0]        fov_nxt;

  always_comb begin
    case (cmd_r) inside
      flcam_pkg::CMD_FWD, flcam_pkg::CMD_BACK:  mvec = front_r[cmd.comp];
      flcam_pkg::CMD_LEFT, flcam_pkg::CMD_RIGHT: mvec = right_r[cmd.comp];
      default:                                   mvec = up_r[cmd.comp];
    endcase
    case (cmd_r) inside
      flcam_pkg::CMD_BACK, flcam_pkg::CMD_LEFT, flcam_pkg::CMD_DOWN: mminus = 1'b1;
      default: mminus = 1'b0;
    endcase
    mprod  = $signed({1'b0, vel_r}) * mvec;
    mround = mprod + 49'sd2097152;
    mstep  = mround[48:22];
    mpos   = mminus ?
             $signed({{2{pos_r[cmd.comp][31]}}, pos_r[cmd.comp]}) -
             $signed({{7{mstep[26]}}, mstep}) :
             $signed({{2{pos_r[cmd.comp][31]}}, pos_r[cmd.comp]}) +
             $signed({{7{mstep[26]}}, mstep});
    if (mpos > 34'sd2147483647) begin
      mpos_sat = 32'sh7FFFFFFF;
    end else if (mpos < -34'sd2147483648) begin
      mpos_sat = 32'sh80000000;
    end else begin
      mpos_sat = mpos[31:0];
    end
    fz = $signed({12'd0, fov_r, 8'd0}) - $signed({{2{yo_r[31]}}, yo_r});
    if (fz < flcam_pkg::FOV_MIN) begin
      fov_nxt = flcam_pkg::FOV_MIN[21:8];
    end else if (fz > flcam_pkg::FOV_MAX) begin
      fov_nxt = flcam_pkg::FOV_MAX[21:8];
    end else begin
      fov_nxt = fz[21:8];
    end
  end

  // Architectural state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r     <= flcam_pkg::SENS_RESET;
      speed_r    <= flcam_pkg::SPEED_RESET;
      wup_r[0]   <= '0;
      wup_r[1]   <= flcam_pkg::ONE14;
      wup_r[2]   <= '0;
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      pos_r[2]   <= '0;
      front_r[0] <= '0;
      front_r[1] <= '0;
      front_r[2] <= -flcam_pkg::ONE14;
      right_r[0] <= flcam_pkg::ONE14;
      right_r[1] <= '0;
      right_r[2] <= '0;
      up_r[0]    <= '0;
      up_r[1]    <= flcam_pkg::ONE14;
      up_r[2]    <= '0;
      yaw_r      <= flcam_pkg::YAW_RESET;
      pitch_r    <= '0;
      fov_r      <= flcam_pkg::FOV_RESET;
      cmd_r      <= flcam_pkg::CMD_LOOK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          flcam_pkg::REG_SENS:  sens_r   <= cfg_wdata;
          flcam_pkg::REG_SPEED: speed_r  <= cfg_wdata;
          flcam_pkg::REG_WUP_X: wup_r[0] <= $signed(cfg_wdata);
          flcam_pkg::REG_WUP_Y: wup_r[1] <= $signed(cfg_wdata);
          flcam_pkg::REG_WUP_Z: wup_r[2] <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      case (cmd.op)
        flcam_pkg::OP_LOAD: cmd_r <= flcam_pkg::cmd_t'(in_command);
        flcam_pkg::OP_DY:   pitch_r <= pitch_nxt;
        flcam_pkg::OP_YRED: begin
          if (cmd.cnt == 5'd0) begin
            yaw_r <= red_sub[24:0];
          end
        end
        flcam_pkg::OP_DFIN: begin
          case (cmd.sel)
            2'd0:    front_r[cmd.comp] <= norm_res;
            2'd1:    right_r[cmd.comp] <= norm_res;
            default: up_r[cmd.comp]    <= norm_res;
          endcase
        end
        flcam_pkg::OP_ZOOM: fov_r <= fov_nxt;
        flcam_pkg::OP_MOVE: pos_r[cmd.comp] <= mpos_sat;
        default: ;
      endcase
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      flcam_pkg::OP_LOAD: begin
        xo_r <= in_x_offset;
        yo_r <= in_y_offset;
        dt_r <= in_delta_time;
      end
      flcam_pkg::OP_DX:   red_r <= yaw_wrap;
      flcam_pkg::OP_YRED: red_r <= red_sub;
      flcam_pkg::OP_CINIT: begin
        cx_r  <= flcam_pkg::CORDIC_GAIN;
        cy_r  <= '0;
        ca_r  <= ang_nxt;
        neg_r <= neg_nxt;
      end
      flcam_pkg::OP_CSTEP: begin
        if (rot_pos) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          ca_r <= ca_r - atan_w;
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          ca_r <= ca_r + atan_w;
        end
      end
      flcam_pkg::OP_CFIN: begin
        if (cmd.sel == 2'd0) begin
          cosy_r <= cos_fin[31:0];
          siny_r <= sin_fin[31:0];
        end else begin
          cosp_r <= cos_fin[31:0];
          sinp_r <= sin_fin[31:0];
        end
      end
      flcam_pkg::OP_FMUL0: v_r[0] <= fp0[61:30];
      flcam_pkg::OP_FMUL2: begin
        v_r[1] <= sinp_r;
        v_r[2] <= fp2[61:30];
      end
      flcam_pkg::OP_CROSS: v_r[cmd.comp] <= cross_v;
      flcam_pkg::OP_SQ:    sum_r <= (cmd.comp == 2'd0) ? sq : sum_r + sq;
      flcam_pkg::OP_SQRTI: begin
        sn_r <= sum_r;
        sr_r <= '0;
      end
      flcam_pkg::OP_SQRT: begin
        if (sqrt_ge) begin
          sn_r <= sn_r - sqrt_trial[63:0];
          sr_r <= (sr_r >> 1) + sqrt_bit;
        end else begin
          sr_r <= sr_r >> 1;
        end
      end
      flcam_pkg::OP_DIVI: begin
        rem_r <= div_num;
        den_r <= {len, 1'b0};
        q_r   <= '0;
      end
      flcam_pkg::OP_DSTEP: begin
        if (div_ge) begin
          rem_r <= rem_r - div_thr[47:0];
        end
        q_r <= {q_r[15:0], div_ge};
      end
      flcam_pkg::OP_VEL: vel_r <= dt_r * speed_r;
      flcam_pkg::OP_PUBLISH: begin
        opos_r   <= pos_r;
        ofront_r <= front_r;
        oup_r    <= up_r;
        ofov_r   <= fov_r;
        oyaw_r   <= yaw_r;
        opitch_r <= pitch_r;
      end
      default: ;
    endcase
  end

  assign out_pos_x         = opos_r[0];
  assign out_pos_y         = opos_r[1];
  assign out_pos_z         = opos_r[2];
  assign out_front_x       = ofront_r[0];
  assign out_front_y       = ofront_r[1];
  assign out_front_z       = ofront_r[2];
  assign out_up_x          = oup_r[0];
  assign out_up_y          = oup_r[1];
  assign out_up_z          = oup_r[2];
  assign out_field_of_view = ofov_r;
  assign out_yaw_out       = oyaw_r;
  assign out_pitch_out     = opitch_r;

endmodule
